// File: rtl/hta_pkg.sv
// Shared constants, action codes and types for the handle table allocator.
`default_nettype none

package hta_pkg;

    localparam int HANDLE_SPACE      = 256;
    localparam int DEF_GROUP_COUNT   = 16;
    localparam int DEF_GROUP_SIZE    = 16;

    localparam int HANDLE_W          = 8;
    localparam int TOTAL_W           = 9;
    localparam int OBJECT_W          = 32;
    localparam int FLAGS_W           = 32;
    localparam int TYPE_W            = 16;
    localparam int ACTION_W          = 3;

    // The free slot search works on chunks of the occupancy vector.
    localparam int CHUNK             = 16;
    localparam int CHUNK_W           = 4;

    localparam int S_TDATA_W         = 96;
    localparam int M_TDATA_W         = 104;

    localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLOSE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESOLVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [OBJECT_W-1:0] object;
        logic [FLAGS_W-1:0]  flags;
        logic [TYPE_W-1:0]   stype;
    } slot_entry_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] handle;
    } search_res_t;

endpackage

`default_nettype wire

// File: rtl/hta_slot_mem.sv
// Single-port-write, registered-read memory holding the contents of every slot.
`default_nettype none

module hta_slot_mem
    import hta_pkg::*;
#(
    parameter int DEPTH = HANDLE_SPACE,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic        aclk,
    input  wire logic        wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire slot_entry_t wr_data,
    input  wire logic        rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output slot_entry_t      rd_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/hta_free_search.sv
// Two-step search for the lowest free slot outside the first group.
`default_nettype none

module hta_free_search
    import hta_pkg::*;
#(
    parameter int USABLE     = HANDLE_SPACE,
    parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
    input  wire logic              aclk,
    input  wire logic              load_en,
    input  wire logic [USABLE-1:0] occ,
    output search_res_t            result
);

    localparam int NCHUNK = (USABLE + CHUNK - 1) / CHUNK;
    localparam int PAD_W  = NCHUNK * CHUNK;

    logic [PAD_W-1:0]  free_vec;
    logic [NCHUNK-1:0] chunk_any_next;
    logic [NCHUNK-1:0] chunk_any_reg;
    logic [CHUNK_W-1:0] sel_chunk;
    logic [CHUNK_W-1:0] sel_slot;
    logic [CHUNK-1:0]  chunk_bits;
    logic              any_found;

    for (genvar i = 0; i < PAD_W; i++) begin : g_free
        if (i < USABLE && i >= GROUP_SIZE) begin : g_live
            assign free_vec[i] = ~occ[i];
        end else begin : g_dead
            assign free_vec[i] = 1'b0;
        end
    end

    always_comb begin
        for (int c = 0; c < NCHUNK; c++) begin
            chunk_any_next[c] = |free_vec[c*CHUNK +: CHUNK];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            chunk_any_reg <= chunk_any_next;
        end
    end

    always_comb begin
        sel_chunk  = '0;
        any_found  = 1'b0;
        for (int c = NCHUNK - 1; c >= 0; c--) begin
            if (chunk_any_reg[c]) begin
                sel_chunk = CHUNK_W'(c);
                any_found = 1'b1;
            end
        end
        chunk_bits = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (sel_chunk == CHUNK_W'(c)) begin
                chunk_bits = free_vec[c*CHUNK +: CHUNK];
            end
        end
        sel_slot = '0;
        for (int s = CHUNK - 1; s >= 0; s--) begin
            if (chunk_bits[s]) begin
                sel_slot = CHUNK_W'(s);
            end
        end
    end

    assign result.found  = any_found;
    assign result.handle = {sel_chunk, sel_slot};

endmodule

`default_nettype wire

// File: rtl/handle_table_allocator.sv
// Handle table allocator: slot memory, occupancy bits, free search and sequencer.
// Each transaction passes through the states accept, slot memory read, update and result load, in that order.
// The result goes to the master side from the output register loaded in the result load state.
// The slot memory read-modify-write is not overlapped: a new transaction is accepted only when idle.
// Reset clears the occupancy bits, the open count and the destroy flag at once.
// The slot memory is not reset; an unoccupied slot is never read for a result.
`default_nettype none

module handle_table_allocator
    import hta_pkg::*;
#(
    parameter int GROUP_COUNT = DEF_GROUP_COUNT,
    parameter int GROUP_SIZE  = DEF_GROUP_SIZE
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // action[2:0], handle_index[10:3], object_ref[42:11], flag_bits[74:43],
    // type_bits[90:75], zero fill above.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[0], out_handle[8:1], out_object[40:9], out_flags[72:41],
    // out_type[88:73], open_total[97:89], zero fill above.
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int SLOT_TOTAL = GROUP_COUNT * GROUP_SIZE;
    localparam int USABLE     = (SLOT_TOTAL < HANDLE_SPACE) ? SLOT_TOTAL : HANDLE_SPACE;
    localparam int AW         = $clog2(USABLE);
    localparam logic [TOTAL_W-1:0] USABLE_W = TOTAL_W'(USABLE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [ACTION_W-1:0]    action_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [OBJECT_W-1:0]    object_reg;
    logic [FLAGS_W-1:0]     flags_reg;
    logic [TYPE_W-1:0]      type_reg;
    logic [USABLE-1:0]      occ_reg, occ_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   closed_reg, closed_next;
    logic                   status_reg, status_next;
    logic [HANDLE_W-1:0]    ohandle_reg, ohandle_next;
    slot_entry_t            oentry_reg, oentry_next;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   accept;
    logic                   out_free;
    logic                   in_range;
    logic                   hvalid;
    logic                   hocc;
    logic [AW-1:0]          hidx;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    slot_entry_t            mem_wr_data;
    slot_entry_t            mem_rd_data;
    search_res_t            search;
    slot_entry_t            new_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign hidx     = handle_reg[AW-1:0];
    assign in_range = {1'b0, handle_reg} < USABLE_W;
    assign hvalid   = (handle_reg != '0) && in_range;
    assign hocc     = in_range && occ_reg[hidx];

    assign new_entry.object = object_reg;
    assign new_entry.flags  = flags_reg;
    assign new_entry.stype  = type_reg;

    hta_slot_mem #(
        .DEPTH (USABLE),
        .AW    (AW)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (hidx),
        .rd_data (mem_rd_data)
    );

    hta_free_search #(
        .USABLE     (USABLE),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_free_search (
        .aclk    (aclk),
        .load_en (state_reg == ST_READ),
        .occ     (occ_reg),
        .result  (search)
    );

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        total_next   = total_reg;
        closed_next  = closed_reg;
        status_next  = status_reg;
        ohandle_next = ohandle_reg;
        oentry_next  = oentry_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = hidx;
        mem_wr_data  = new_entry;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next   = ST_DONE;
                status_next  = STATUS_FAIL;
                ohandle_next = handle_reg;
                oentry_next  = '0;
                case (action_reg)
                    ACT_OPEN: begin
                        ohandle_next = '0;
                        if (!closed_reg && object_reg != '0) begin
                            if (handle_reg != '0) begin
                                if (in_range && !hocc) begin
                                    mem_wr_en      = 1'b1;
                                    occ_next[hidx] = 1'b1;
                                    total_next     = total_reg + 1'b1;
                                    ohandle_next   = handle_reg;
                                    status_next    = STATUS_OK;
                                end
                            end else if (search.found) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = search.handle[AW-1:0];
                                occ_next[search.handle[AW-1:0]] = 1'b1;
                                total_next   = total_reg + 1'b1;
                                ohandle_next = search.handle;
                                status_next  = STATUS_OK;
                            end
                        end
                    end
                    ACT_CLOSE: begin
                        if (hvalid && hocc) begin
                            oentry_next    = mem_rd_data;
                            occ_next[hidx] = 1'b0;
                            total_next     = total_reg - 1'b1;
                            status_next    = STATUS_OK;
                        end
                    end
                    ACT_MODIFY: begin
                        if (hvalid && hocc) begin
                            mem_wr_en         = 1'b1;
                            mem_wr_data       = mem_rd_data;
                            mem_wr_data.flags = flags_reg;
                            status_next       = STATUS_OK;
                        end
                    end
                    ACT_RESOLVE: begin
                        if (hvalid && hocc && (mem_rd_data.stype & type_reg) != '0) begin
                            oentry_next = mem_rd_data;
                            status_next = STATUS_OK;
                        end
                    end
                    ACT_DESTROY: begin
                        closed_next = 1'b1;
                        status_next = STATUS_OK;
                    end
                    default: begin
                        status_next = STATUS_FAIL;
                    end
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            total_reg    <= '0;
            closed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            total_reg  <= total_next;
            closed_reg <= closed_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_tdata[2:0];
            handle_reg <= s_tdata[10:3];
            object_reg <= s_tdata[42:11];
            flags_reg  <= s_tdata[74:43];
            type_reg   <= s_tdata[90:75];
        end
        status_reg  <= status_next;
        ohandle_reg <= ohandle_next;
        oentry_reg  <= oentry_next;
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {6'b0, total_reg, oentry_reg.stype, oentry_reg.flags,
                            oentry_reg.object, ohandle_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_total_matches_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == TOTAL_W'($countones(occ_reg)))
        else $error("Open count differs from the number of occupied slots.");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[97:89] <= USABLE_W)
        else $error("Reported open count exceeds the usable handle range.");

    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && search.found) |->
            ({1'b0, search.handle} >= TOTAL_W'(GROUP_SIZE) &&
             {1'b0, search.handle} < USABLE_W))
        else $error("Free search returned a handle outside the searchable range.");

    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_READ)
        else $error("Accepted transaction did not start a slot read.");

endmodule

`default_nettype wire

// File: tb/tb_handle_table_allocator.sv
// Self-checking testbench for the handle table allocator with a shadow table and result scoreboard.
`default_nettype none

import hta_pkg::*;

typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle;
    logic [OBJECT_W-1:0] obj;
    logic [FLAGS_W-1:0]  flags;
    logic [TYPE_W-1:0]   stype;
} request_t;

typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle;
    logic [OBJECT_W-1:0] obj;
    logic [FLAGS_W-1:0]  flags;
    logic [TYPE_W-1:0]   stype;
    logic [TOTAL_W-1:0]  total;
} reply_t;

class handle_table_shadow;
    localparam int SLOTS  = DEF_GROUP_COUNT * DEF_GROUP_SIZE;
    localparam int USABLE = (SLOTS < HANDLE_SPACE) ? SLOTS : HANDLE_SPACE;

    logic [OBJECT_W-1:0] slot_obj [SLOTS];
    logic [FLAGS_W-1:0]  slot_flags [SLOTS];
    logic [TYPE_W-1:0]   slot_type [SLOTS];
    int                  group_fill [DEF_GROUP_COUNT];
    int                  open_count;
    bit                  table_shut;
    reply_t              awaited_replies [$];
    int                  errors;
    int                  checked;
    int                  requests;
    int                  opens_granted;
    int                  full_refusals;
    int                  closes_done;
    int                  resolves_done;
    int                  peak_open;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            slot_obj[i] = '0;
            slot_flags[i] = '0;
            slot_type[i] = '0;
        end
        for (int g = 0; g < DEF_GROUP_COUNT; g++) group_fill[g] = 0;
        open_count = 0;
        table_shut = 0;
        errors = 0;
        checked = 0;
        requests = 0;
        opens_granted = 0;
        full_refusals = 0;
        closes_done = 0;
        resolves_done = 0;
        peak_open = 0;
    endfunction

    function logic [HANDLE_W-1:0] pick_handle();
        int live;
        int k;
        live = 0;
        for (int h = 1; h < USABLE; h++) if (slot_obj[h] != 0) live++;
        if (live == 0 || $urandom_range(0, 99) < 15) return HANDLE_W'($urandom_range(0, 255));
        k = $urandom_range(0, live - 1);
        for (int h = 1; h < USABLE; h++) begin
            if (slot_obj[h] != 0) begin
                if (k == 0) return HANDLE_W'(h);
                k--;
            end
        end
        return '0;
    endfunction

    function void note_request(request_t r);
        reply_t e;
        int h;
        int f;
        bit live;
        e = '0;
        e.status = STATUS_FAIL;
        e.handle = r.handle;
        h = r.handle;
        live = (h != 0) && (h < USABLE) && (slot_obj[h] != 0);
        requests++;
        case (r.action)
            ACT_OPEN: begin
                e.handle = '0;
                if (!table_shut && r.obj != 0) begin
                    f = 0;
                    if (h != 0) begin
                        if (h < USABLE && slot_obj[h] == 0) f = h;
                    end else begin
                        for (int g = 1; g < DEF_GROUP_COUNT && f == 0; g++) begin
                            if (group_fill[g] < DEF_GROUP_SIZE) begin
                                for (int s = 0; s < DEF_GROUP_SIZE && f == 0; s++) begin
                                    if (g * DEF_GROUP_SIZE + s >= USABLE) break;
                                    if (slot_obj[g * DEF_GROUP_SIZE + s] == 0)
                                        f = g * DEF_GROUP_SIZE + s;
                                end
                            end
                        end
                        if (f == 0) full_refusals++;
                    end
                    if (f != 0) begin
                        slot_obj[f] = r.obj;
                        slot_flags[f] = r.flags;
                        slot_type[f] = r.stype;
                        group_fill[f / DEF_GROUP_SIZE]++;
                        open_count++;
                        e.handle = HANDLE_W'(f);
                        e.status = STATUS_OK;
                        opens_granted++;
                    end
                end
            end
            ACT_CLOSE: begin
                if (live) begin
                    e.obj = slot_obj[h];
                    e.flags = slot_flags[h];
                    e.stype = slot_type[h];
                    slot_obj[h] = '0;
                    slot_flags[h] = '0;
                    slot_type[h] = '0;
                    if (group_fill[h / DEF_GROUP_SIZE] != 0) group_fill[h / DEF_GROUP_SIZE]--;
                    if (open_count != 0) open_count--;
                    e.status = STATUS_OK;
                    closes_done++;
                end
            end
            ACT_MODIFY: begin
                if (live) begin
                    slot_flags[h] = r.flags;
                    e.status = STATUS_OK;
                end
            end
            ACT_RESOLVE: begin
                if (live && (slot_type[h] & r.stype) != 0) begin
                    e.obj = slot_obj[h];
                    e.flags = slot_flags[h];
                    e.stype = slot_type[h];
                    e.status = STATUS_OK;
                    resolves_done++;
                end
            end
            ACT_DESTROY: begin
                table_shut = 1;
                e.status = STATUS_OK;
            end
            default: ;
        endcase
        if (open_count > peak_open) peak_open = open_count;
        e.total = TOTAL_W'(open_count);
        awaited_replies.push_back(e);
    endfunction

    function void check_reply(reply_t got);
        reply_t want;
        string bad;
        checked++;
        if (awaited_replies.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result transaction: st=%0d h=%0d obj=%h fl=%h ty=%h tot=%0d",
                         got.status, got.handle, got.obj, got.flags, got.stype, got.total);
            return;
        end
        want = awaited_replies.pop_front();
        bad = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.handle !== want.handle) bad = {bad, " handle"};
        if (got.obj !== want.obj) bad = {bad, " object"};
        if (got.flags !== want.flags) bad = {bad, " flags"};
        if (got.stype !== want.stype) bad = {bad, " type"};
        if (got.total !== want.total) bad = {bad, " total"};
        if (bad != "") begin
            errors++;
            if (errors <= 10) begin
                $display("Mismatch in%s: expected st=%0d h=%0d obj=%h fl=%h ty=%h tot=%0d",
                         bad, want.status, want.handle, want.obj, want.flags, want.stype,
                         want.total);
                $display("    got st=%0d h=%0d obj=%h fl=%h ty=%h tot=%0d",
                         got.status, got.handle, got.obj, got.flags, got.stype, got.total);
            end
        end
    endfunction
endclass

module tb_handle_table_allocator;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [ACTION_W-1:0] ACT_LAST = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    handle_table_shadow shadow;
    int  cycles = 0;
    bit  tx_calm;
    bit  rx_calm;

    handle_table_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [HANDLE_W-1:0] h,
                             input logic [OBJECT_W-1:0] obj, input logic [FLAGS_W-1:0] fl,
                             input logic [TYPE_W-1:0] ty);
        request_t r;
        int gap;
        r.action = act;
        r.handle = h;
        r.obj = obj;
        r.flags = fl;
        r.stype = ty;
        gap = pick_gap(tx_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, ty, fl, obj, h, act};
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(r);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (shadow.awaited_replies.size() != 0) @(negedge aclk);
    endtask

    task automatic run_block(input int kind);
        int roll;
        int open_w;
        int close_w;
        int rest;
        logic [HANDLE_W-1:0] h;
        logic [TYPE_W-1:0]   ty;
        logic [OBJECT_W-1:0] obj;
        open_w = (kind == 0) ? 90 : (kind == 1) ? 15 : 40;
        close_w = (kind == 0) ? 2 : (kind == 1) ? 60 : 25;
        rest = 100 - open_w - close_w;
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 50; i++) begin
            roll = $urandom_range(0, 99);
            ty = ($urandom_range(0, 19) == 0) ? TYPE_W'($urandom)
                                              : TYPE_W'(1) << $urandom_range(0, 15);
            obj = ($urandom_range(0, 29) == 0) ? '0 : OBJECT_W'($urandom);
            if (roll < open_w) begin
                h = ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom_range(1, 255)) : '0;
                send_item(ACT_OPEN, h, obj, $urandom, ty);
            end else if (roll < open_w + close_w) begin
                send_item(ACT_CLOSE, shadow.pick_handle(), obj, $urandom, ty);
            end else if (roll < open_w + close_w + rest * 3 / 10) begin
                send_item(ACT_MODIFY, shadow.pick_handle(), obj, $urandom, ty);
            end else if (roll < open_w + close_w + rest * 85 / 100) begin
                h = shadow.pick_handle();
                case ($urandom_range(0, 3))
                    0, 1: ty = shadow.slot_type[h];
                    2: ty = ~shadow.slot_type[h];
                    default: ty = TYPE_W'($urandom);
                endcase
                send_item(ACT_RESOLVE, h, obj, $urandom, ty);
            end else begin
                send_item(ACTION_W'($urandom_range(ACT_DESTROY + 1, ACT_LAST)),
                          HANDLE_W'($urandom), $urandom, $urandom, TYPE_W'($urandom));
            end
        end
    endtask

    initial begin
        reply_t got;
        int gap;
        int seen;
        seen = 0;
        m_tready = 1'b0;
        forever begin
            if (seen % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            gap = pick_gap(rx_calm);
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            got.status = m_tdata[0];
            got.handle = m_tdata[8:1];
            got.obj = m_tdata[40:9];
            got.flags = m_tdata[72:41];
            got.stype = m_tdata[88:73];
            got.total = m_tdata[97:89];
            shadow.check_reply(got);
            seen++;
        end
    end

    initial begin
        int kinds [11];
        logic [HANDLE_W-1:0] h;
        kinds = '{0, 0, 0, 0, 2, 0, 0, 0, 1, 1, 1};
        shadow = new();
        tx_calm = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(ACT_OPEN, 8'd0, 32'h1, 32'h0, 16'h0001);
        send_item(ACT_OPEN, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
        send_item(ACT_OPEN, 8'd1, 32'h5, 32'hA5A5_5A5A, 16'h0002);
        send_item(ACT_OPEN, 8'd255, 32'h8000_0000, 32'h1, 16'hFFFF);
        send_item(ACT_OPEN, 8'd16, 32'h7, 32'h7, 16'h0004);
        send_item(ACT_OPEN, 8'd0, 32'h0, 32'h3, 16'h0008);
        send_item(ACT_OPEN, 8'd1, 32'h9, 32'h9, 16'h0010);
        send_item(ACT_CLOSE, 8'd0, 32'h0, 32'h0, 16'h0);
        send_item(ACT_MODIFY, 8'd0, 32'h0, 32'hFFFF_FFFF, 16'h0);
        send_item(ACT_RESOLVE, 8'd0, 32'h0, 32'h0, 16'hFFFF);
        send_item(ACT_MODIFY, 8'd17, 32'h0, 32'h0, 16'h0);
        send_item(ACT_RESOLVE, 8'd17, 32'h0, 32'h0, 16'h8000);
        send_item(ACT_RESOLVE, 8'd17, 32'h0, 32'h0, 16'h7FFF);
        send_item(ACT_RESOLVE, 8'd255, 32'h0, 32'h0, 16'h0);
        send_item(ACT_RESOLVE, 8'd2, 32'h0, 32'h0, 16'hFFFF);
        send_item(ACT_MODIFY, 8'd2, 32'h0, 32'h1234_5678, 16'h0);
        send_item(ACT_CLOSE, 8'd16, 32'h0, 32'h0, 16'h0);
        send_item(ACT_CLOSE, 8'd16, 32'h0, 32'h0, 16'h0);
        send_item(ACT_OPEN, 8'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D, 16'h0100);
        send_item(ACT_CLOSE, 8'd255, 32'h0, 32'h0, 16'h0);
        for (int a = ACT_DESTROY + 1; a <= ACT_LAST; a++)
            send_item(ACTION_W'(a), 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        wait_drained();

        for (int b = 0; b < 11; b++) begin
            run_block(kinds[b]);
            if (b == 4 || b == 7) wait_drained();
        end
        wait_drained();

        tx_calm = 0;
        send_item(ACT_DESTROY, 8'd0, 32'h0, 32'h0, 16'h0);
        send_item(ACT_DESTROY, 8'hAA, 32'h1, 32'h1, 16'h1);
        send_item(ACT_OPEN, 8'd0, 32'h55, 32'h55, 16'h0001);
        send_item(ACT_OPEN, 8'd3, 32'h55, 32'h55, 16'h0001);
        h = shadow.pick_handle();
        send_item(ACT_RESOLVE, h, 32'h0, 32'h0, shadow.slot_type[h]);
        send_item(ACT_MODIFY, h, 32'h0, 32'h0F0F_0F0F, 16'h0);
        send_item(ACT_CLOSE, h, 32'h0, 32'h0, 16'h0);
        wait_drained();
        repeat (16) @(posedge aclk);

        $display("Ran %0d transactions: %0d opens granted, %0d refused on a full table, %0d closes,",
                 shadow.requests, shadow.opens_granted, shadow.full_refusals, shadow.closes_done);
        $display("%0d resolves, peak occupancy %0d; %0d results checked, %0d mismatches.",
                 shadow.resolves_done, shadow.peak_open, shadow.checked, shadow.errors);
        if (shadow.errors == 0 && shadow.awaited_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
